// File: sv/nrd_pkg.sv
// Package for the non-restoring unsigned divider.
// Holds the operand width, the channel item types and the per-cell state type.
// No dependencies.
`default_nettype none

package nrd_pkg;

  localparam int DIV_WIDTH = 8;
  localparam int ACC_WIDTH = DIV_WIDTH + 1;

  typedef struct packed {
    logic [DIV_WIDTH-1:0] dividend_value;
    logic [DIV_WIDTH-1:0] divisor_value;
  } req_t;

  typedef struct packed {
    logic [DIV_WIDTH-1:0] quotient_value;
    logic [DIV_WIDTH-1:0] remainder_value;
  } rsp_t;

  // partial state carried from cell to cell
  typedef struct packed {
    logic [ACC_WIDTH-1:0] acc;
    logic [DIV_WIDTH-1:0] quo;
    logic [DIV_WIDTH-1:0] dvs;
  } stage_t;

endpackage

`default_nettype wire

// File: sv/nrd_if.sv
// Valid/ready channel interfaces for the divider request and response items.
// Depends on nrd_pkg.
`default_nettype none

interface nrd_req_if;
  import nrd_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nrd_rsp_if;
  import nrd_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/nrd_cell.sv
// One non-restoring division step: shift, add or subtract, registered.
// Depends on nrd_pkg.
`default_nettype none

module nrd_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  input  nrd_pkg::stage_t up_data,
  output logic            up_ready,
  output logic            dn_valid,
  output nrd_pkg::stage_t dn_data,
  input  logic            dn_ready
);
  import nrd_pkg::*;

  logic                 valid;
  stage_t               data;
  stage_t               data_next;
  logic [ACC_WIDTH-1:0] shifted;
  logic [ACC_WIDTH-1:0] dvs_ext;
  logic [ACC_WIDTH-1:0] sum;

  assign shifted = {up_data.acc[DIV_WIDTH-1:0], up_data.quo[DIV_WIDTH-1]};
  assign dvs_ext = {1'b0, up_data.dvs};
  assign sum     = up_data.acc[DIV_WIDTH] ? shifted + dvs_ext : shifted - dvs_ext;

  always_comb begin
    data_next.acc = sum;
    data_next.quo = {up_data.quo[DIV_WIDTH-2:0], ~sum[DIV_WIDTH]};
    data_next.dvs = up_data.dvs;
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

`default_nettype wire

// File: sv/nrd_fix.sv
// Output stage: adds the divisor back to a negative remainder and holds the
// result item until taken. Depends on nrd_pkg and nrd_rsp_if.
`default_nettype none

module nrd_fix (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  input  nrd_pkg::stage_t   up_data,
  output logic              up_ready,
  nrd_rsp_if.source         rsp
);
  import nrd_pkg::*;

  logic                 valid;
  rsp_t                 data;
  logic [ACC_WIDTH-1:0] rem;

  assign rem = up_data.acc[DIV_WIDTH] ? up_data.acc + {1'b0, up_data.dvs} : up_data.acc;

  assign up_ready = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data.quotient_value  <= up_data.quo;
      data.remainder_value <= rem[DIV_WIDTH-1:0];
    end
  end

  assign rsp.valid = valid;
  assign rsp.data  = data;

endmodule

`default_nettype wire

// File: sv/non_restoring_unsigned_divider.sv
// Top level of the non-restoring unsigned divider: a row of step cells and
// an output stage. Depends on nrd_pkg, nrd_if, nrd_cell and nrd_fix.
//
// Usage:
//   req carries one division (dividend_value, divisor_value) per item;
//   rsp returns quotient_value and remainder_value, one item per request,
//   in request order. A zero divisor gives an all-ones quotient and the
//   dividend as remainder.
//   There is one cell per quotient bit, then the remainder correction in
//   the output register. Throughput is one item per cycle while rsp does
//   not stall; every cell holds its own item.
//   When rsp stalls, items close up behind the output register and req.ready
//   drops only once every cell holds an item.
//   Synchronous reset empties all cells and the output register; no result
//   is pending after reset.
`default_nettype none

module non_restoring_unsigned_divider (
  input  logic       clk,
  input  logic       rst,
  nrd_req_if.sink    req,
  nrd_rsp_if.source  rsp
);
  import nrd_pkg::*;

  logic   vld [DIV_WIDTH+1];
  logic   rdy [DIV_WIDTH+1];
  stage_t stg [DIV_WIDTH+1];
  logic   all_full;

  always_comb begin
    stg[0].acc = '0;
    stg[0].quo = req.data.dividend_value;
    stg[0].dvs = req.data.divisor_value;
  end
  assign vld[0]    = req.valid;
  assign req.ready = rdy[0];

  for (genvar i = 0; i < DIV_WIDTH; i++) begin : g_cell
    nrd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld[i]),
      .up_data  (stg[i]),
      .up_ready (rdy[i]),
      .dn_valid (vld[i+1]),
      .dn_data  (stg[i+1]),
      .dn_ready (rdy[i+1])
    );
  end

  nrd_fix u_fix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (vld[DIV_WIDTH]),
    .up_data  (stg[DIV_WIDTH]),
    .up_ready (rdy[DIV_WIDTH]),
    .rsp      (rsp)
  );

  always_comb begin
    all_full = rsp.valid;
    for (int k = 1; k <= DIV_WIDTH; k++) begin
      all_full = all_full && vld[k];
    end
  end

`ifndef SYNTHESIS
  a_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_WIDTH] && stg[DIV_WIDTH].dvs == '0 |->
      (&stg[DIV_WIDTH].quo) && !stg[DIV_WIDTH].acc[DIV_WIDTH])
    else $error("zero divisor did not give all-ones quotient");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_WIDTH] && !stg[DIV_WIDTH].acc[DIV_WIDTH] && stg[DIV_WIDTH].dvs != '0 |->
      stg[DIV_WIDTH].acc < {1'b0, stg[DIV_WIDTH].dvs})
    else $error("positive partial remainder not below divisor");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> all_full && !rsp.ready)
    else $error("request stalled while a cell is empty");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> vld[1])
    else $error("accepted item missing from first cell");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_non_restoring_unsigned_divider.sv
// Testbench for non_restoring_unsigned_divider: drives division items, predicts
// quotient and remainder per item and checks every response in order.
// Depends on nrd_pkg, nrd_if and the divider RTL.
`timescale 1ns / 1ps

module tb_non_restoring_unsigned_divider;
  import nrd_pkg::*;

  localparam int IDLE_PCT    = 31;
  localparam int DRAIN_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic no_gaps = 1'b0;
  int   error_count = 0;
  rsp_t pending_results[$];

  nrd_req_if req_ch ();
  nrd_rsp_if rsp_ch ();

  non_restoring_unsigned_divider u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
  end

  // Bit-serial non-restoring division on a DIV_WIDTH+1 accumulator.
  function automatic rsp_t divide_nonrestoring(req_t div_req);
    logic [ACC_WIDTH-1:0] acc;
    logic [DIV_WIDTH-1:0] quo;
    logic [DIV_WIDTH-1:0] dvs;
    logic                 was_neg;
    rsp_t                 res;
    acc = '0;
    quo = div_req.dividend_value;
    dvs = div_req.divisor_value;
    for (int i = 0; i < DIV_WIDTH; i++) begin
      was_neg = acc[ACC_WIDTH-1];
      {acc, quo} = {acc, quo} << 1;
      if (was_neg) begin
        acc = acc + {1'b0, dvs};
      end else begin
        acc = acc - {1'b0, dvs};
      end
      quo[0] = ~acc[ACC_WIDTH-1];
    end
    if (acc[ACC_WIDTH-1]) begin
      acc = acc + {1'b0, dvs};
    end
    res.quotient_value  = quo;
    res.remainder_value = acc[DIV_WIDTH-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Response check first, then record the item accepted at this edge.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no division pending: quotient_value %0d remainder_value %0d",
                 rsp_ch.data.quotient_value, rsp_ch.data.remainder_value);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.data.quotient_value !== want.quotient_value) begin
            $error("quotient_value mismatch: expected %0d, actual %0d",
                   want.quotient_value, rsp_ch.data.quotient_value);
            error_count++;
          end
          if (rsp_ch.data.remainder_value !== want.remainder_value) begin
            $error("remainder_value mismatch: expected %0d, actual %0d",
                   want.remainder_value, rsp_ch.data.remainder_value);
            error_count++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        pending_results.push_back(divide_nonrestoring(req_ch.data));
      end
    end
  end

  task automatic send_division(input logic [DIV_WIDTH-1:0] dividend,
                               input logic [DIV_WIDTH-1:0] divisor);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data.dividend_value <= dividend;
    req_ch.data.divisor_value  <= divisor;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
  endtask

  task automatic test_directed();
    send_division(8'd0, 8'd0);
    send_division(8'd255, 8'd0);
    send_division(8'd1, 8'd0);
    send_division(8'd127, 8'd0);
    send_division(8'd0, 8'd1);
    send_division(8'd255, 8'd1);
    send_division(8'd128, 8'd1);
    send_division(8'd255, 8'd255);
    send_division(8'd254, 8'd255);
    send_division(8'd255, 8'd254);
    send_division(8'd0, 8'd255);
    send_division(8'd1, 8'd255);
    send_division(8'd128, 8'd127);
    send_division(8'd127, 8'd128);
    send_division(8'd128, 8'd128);
    send_division(8'd255, 8'd128);
    send_division(8'd129, 8'd2);
    send_division(8'd200, 8'd3);
    send_division(8'd100, 8'd7);
    send_division(8'd170, 8'd85);
    send_division(8'd85, 8'd170);
    send_division(8'd171, 8'd85);
  endtask

  task automatic test_random(input int count);
    logic [DIV_WIDTH-1:0] dividend;
    logic [DIV_WIDTH-1:0] divisor;
    repeat (count) begin
      dividend = DIV_WIDTH'($urandom());
      case ($urandom_range(0, 9))
        0: divisor = '0;
        1, 2: divisor = DIV_WIDTH'($urandom_range(1, 15));
        3: divisor = DIV_WIDTH'($urandom_range(128, 255));
        4: begin
          divisor = DIV_WIDTH'($urandom_range(1, 255));
          dividend = DIV_WIDTH'(divisor + $urandom_range(0, 2) - 1);
        end
        default: divisor = DIV_WIDTH'($urandom());
      endcase
      send_division(dividend, divisor);
    end
  endtask

  // Full-rate stretch: no sender gaps and no response stalls.
  task automatic test_back_to_back(input int count);
    no_gaps <= 1'b1;
    repeat (count) begin
      send_division(DIV_WIDTH'($urandom()), DIV_WIDTH'($urandom()));
    end
    no_gaps <= 1'b0;
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_back_to_back(250);
    test_random(480);
    req_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    repeat (2 * ACC_WIDTH) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
sv/nrd_pkg.sv
sv/nrd_if.sv
sv/nrd_cell.sv
sv/nrd_fix.sv
sv/non_restoring_unsigned_divider.sv
tb/sv/tb_non_restoring_unsigned_divider.sv
